FILE: rtl/radix2_complex_fft_top_assert.svh
// Assertion macros for the radix-2 FFT block.
// Included by modules that check their own sequencing; needs clk_i and rst_ni in scope.
`ifndef RADIX2_COMPLEX_FFT_TOP_ASSERT_SVH
`define RADIX2_COMPLEX_FFT_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define RCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define RCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rcfft_pkg.sv
// Constants, types and elaboration-time tables for the radix-2 FFT block.
// Used by radix2_complex_fft_top; no dependencies.
`default_nettype none

package rcfft_pkg;

  localparam int Points     = 1024;
  localparam int LogPoints  = $clog2(Points);
  localparam int HalfPoints = Points / 2;
  localparam int Quarter    = Points / 4;
  localparam int TwBits     = 18;
  localparam int FracBits   = TwBits - 2;
  localparam int SampleW    = 24;
  localparam int StoreW     = 36;
  localparam int OutW       = 35;
  localparam int ProdW      = StoreW + TwBits;
  localparam int SumW       = ProdW + 1;
  localparam int TermW      = SumW - FracBits;
  localparam int BflyW      = LogPoints - 1;
  localparam int StageW     = $clog2(LogPoints);
  localparam longint unsigned TwoPiQ32 = 64'd26986075409;

  typedef logic signed [TwBits-1:0] tw_tab_t [HalfPoints];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDBIN,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_WA,
    ST_BF_WB
  } state_e;

  // Restoring long division, used only while the twiddle tables are built.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sine of 2*pi*r/Points in Q1.FracBits from a Q30 Taylor series.
  function automatic longint quarter_sine(input int r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    if (r == 0) return 0;
    if (r >= Quarter) return longint'(1) << FracBits;
    x    = (longint'(r) * TwoPiQ32 + longint'(Points) * 2) >> (LogPoints + 2);
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = udiv64((term * x2) >> 30, longint'((2 * n) * (2 * n + 1)));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + (longint'(1) << (30 - FracBits - 1))) >>> (30 - FracBits);
    if (sum > (longint'(1) << FracBits)) sum = longint'(1) << FracBits;
    return sum;
  endfunction

  function automatic tw_tab_t build_tw(input bit want_cos);
    tw_tab_t tab;
    longint  v;
    for (int k = 0; k < HalfPoints; k++) begin
      if (k <= Quarter) v = want_cos ? quarter_sine(Quarter - k) : quarter_sine(k);
      else v = want_cos ? -quarter_sine(k - Quarter) : quarter_sine(HalfPoints - k);
      tab[k] = v[TwBits-1:0];
    end
    return tab;
  endfunction

  localparam tw_tab_t TwCos = build_tw(1'b1);
  localparam tw_tab_t TwSin = build_tw(1'b0);

  function automatic logic [LogPoints-1:0] bit_rev(input logic [LogPoints-1:0] v);
    logic [LogPoints-1:0] r;
    for (int b = 0; b < LogPoints; b++) r[LogPoints-1-b] = v[b];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rcfft_ram.sv
// Generic simple RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none

module rcfft_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  output      logic [Width-1:0]         rdata_a_o,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output      logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

FILE: rtl/radix2_complex_fft_top.sv
// Radix-2 decimation-in-time FFT: load/read channel, one complex butterfly unit.
// Uses rcfft_pkg, rcfft_ram and radix2_complex_fft_top_assert.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o): mode_i 0 loads the next complex
//   sample, mode_i 1 reads the bin at bin_index_i. Loads give no output item;
//   each read gives exactly one output item on the output channel
//   (out_valid_o / out_stall_i) with bin_re_o, bin_im_o and valid_res_o.
//   Samples are stored at bit-reversed addresses as they arrive. The load that
//   completes the block starts the transform: 10 stages of 512 butterflies,
//   each stepping through read, multiply, sum and write-A/write-B states on
//   the shared complex multiplier and the single write port of the bin RAM,
//   while in_stall_o is high. A read of a finished transform passes the
//   ST_RDBIN state and the output register; any other read only the latter.
//   The input is stalled while an output item waits, so a stalled receiver
//   holds the block. The direction register (cfg channel, always ready) is
//   sampled when a transform starts.
//   Reset clears the load count, the done flag and direction; bin RAM
//   contents are not cleared and need no clearing pass.
`default_nettype none
`include "radix2_complex_fft_top_assert.svh"

module radix2_complex_fft_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output      logic                               in_stall_o,
  input  wire logic                               mode_i,
  input  wire logic signed [rcfft_pkg::SampleW-1:0] sample_re_i,
  input  wire logic signed [rcfft_pkg::SampleW-1:0] sample_im_i,
  input  wire logic [9:0]                         bin_index_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      logic signed [rcfft_pkg::OutW-1:0]  bin_re_o,
  output      logic signed [rcfft_pkg::OutW-1:0]  bin_im_o,
  output      logic                               valid_res_o,
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic                               cfg_direction_i
);

  localparam int LogN = rcfft_pkg::LogPoints;
  localparam int SW   = rcfft_pkg::StoreW;
  localparam int PW   = rcfft_pkg::ProdW;
  localparam int SuW  = rcfft_pkg::SumW;
  localparam int TW   = rcfft_pkg::TermW;
  localparam int OW   = rcfft_pkg::OutW;

  rcfft_pkg::state_e state_q, state_d;

  logic                          dir_cfg_q;
  logic                          dir_q;
  logic                          done_q;
  logic [LogN-1:0]               load_cnt_q;
  logic [rcfft_pkg::StageW-1:0]  stage_q;
  logic [rcfft_pkg::BflyW-1:0]   bfly_q;

  logic signed [rcfft_pkg::TwBits-1:0] wr_q, wi_q;
  logic signed [SW-1:0] a_re_q, a_im_q;
  logic signed [PW-1:0] prr_q, pii_q, pri_q, pir_q;
  logic signed [TW-1:0] t_re_q, t_im_q;

  logic                 out_valid_q;
  logic signed [OW-1:0] bin_re_q, bin_im_q;
  logic                 valid_res_q;

  logic            in_acc, is_load, is_read, last_load, last_bfly;
  logic            ram_we;
  logic [LogN-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [2*SW-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

  logic [LogN-1:0] mask, low, g_addr, p_addr, stage_bit;
  logic [LogN-2:0] tw_idx;

  logic signed [SW-1:0]  b_re, b_im, ra_re, ra_im;
  logic signed [SuW-1:0] sum_re, sum_im;
  logic signed [SW+3:0]  add_re, add_im, sub_re, sub_im;

  function automatic logic signed [SW-1:0] sat_store(input logic signed [SW+3:0] v);
    logic signed [SW+3:0] hi, lo;
    hi = (SW+4)'({1'b0, {(SW-1){1'b1}}});
    lo = -hi - (SW+4)'(1);
    if (v > hi) return hi[SW-1:0];
    if (v < lo) return lo[SW-1:0];
    return v[SW-1:0];
  endfunction

  function automatic logic signed [OW-1:0] sat_out(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo;
    hi = SW'({1'b0, {(OW-1){1'b1}}});
    lo = -hi - SW'(1);
    if (v > hi) return hi[OW-1:0];
    if (v < lo) return lo[OW-1:0];
    return v[OW-1:0];
  endfunction

  assign in_stall_o  = (state_q != rcfft_pkg::ST_IDLE) || out_valid_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign is_load     = in_acc && !mode_i;
  assign is_read     = in_acc && mode_i;
  assign last_load   = load_cnt_q == {LogN{1'b1}};
  assign last_bfly   = (bfly_q == {rcfft_pkg::BflyW{1'b1}}) &&
                       (stage_q == rcfft_pkg::StageW'(LogN - 1));
  assign cfg_ready_o = 1'b1;

  // Butterfly addressing: the stage bit is inserted into the butterfly count.
  assign stage_bit = LogN'(1) << stage_q;
  assign mask      = stage_bit - LogN'(1);
  assign low       = {1'b0, bfly_q} & mask;
  assign g_addr    = (({1'b0, bfly_q} & ~mask) << 1) | low;
  assign p_addr    = g_addr | stage_bit;
  assign tw_idx    = (LogN-1)'(low << (LogN - 1 - int'(stage_q)));

  assign b_re  = ram_rdata_b[2*SW-1:SW];
  assign b_im  = ram_rdata_b[SW-1:0];
  assign ra_re = ram_rdata_a[2*SW-1:SW];
  assign ra_im = ram_rdata_a[SW-1:0];

  assign sum_re = SuW'(prr_q) - SuW'(pii_q) + (SuW'(1) <<< (rcfft_pkg::FracBits - 1));
  assign sum_im = SuW'(pri_q) + SuW'(pir_q) + (SuW'(1) <<< (rcfft_pkg::FracBits - 1));
  assign add_re = (SW+4)'(a_re_q) + (SW+4)'(t_re_q);
  assign add_im = (SW+4)'(a_im_q) + (SW+4)'(t_im_q);
  assign sub_re = (SW+4)'(a_re_q) - (SW+4)'(t_re_q);
  assign sub_im = (SW+4)'(a_im_q) - (SW+4)'(t_im_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      rcfft_pkg::ST_IDLE: begin
        if (is_load && last_load) state_d = rcfft_pkg::ST_BF_RD;
        else if (is_read && done_q) state_d = rcfft_pkg::ST_RDBIN;
      end
      rcfft_pkg::ST_RDBIN:  state_d = rcfft_pkg::ST_IDLE;
      rcfft_pkg::ST_BF_RD:  state_d = rcfft_pkg::ST_BF_MUL;
      rcfft_pkg::ST_BF_MUL: state_d = rcfft_pkg::ST_BF_SUM;
      rcfft_pkg::ST_BF_SUM: state_d = rcfft_pkg::ST_BF_WA;
      rcfft_pkg::ST_BF_WA:  state_d = rcfft_pkg::ST_BF_WB;
      rcfft_pkg::ST_BF_WB:  state_d = last_bfly ? rcfft_pkg::ST_IDLE : rcfft_pkg::ST_BF_RD;
      default:              state_d = rcfft_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = g_addr;
    ram_wdata   = {sat_store(add_re), sat_store(add_im)};
    ram_raddr_a = g_addr;
    ram_raddr_b = p_addr;
    case (state_q)
      rcfft_pkg::ST_IDLE: begin
        ram_we      = is_load;
        ram_waddr   = rcfft_pkg::bit_rev(load_cnt_q);
        ram_wdata   = {SW'(sample_re_i), SW'(sample_im_i)};
        ram_raddr_a = bin_index_i[LogN-1:0];
      end
      rcfft_pkg::ST_BF_WA: ram_we = 1'b1;
      rcfft_pkg::ST_BF_WB: begin
        ram_we    = 1'b1;
        ram_waddr = p_addr;
        ram_wdata = {sat_store(sub_re), sat_store(sub_im)};
      end
      default: ram_we = 1'b0;
    endcase
  end

  rcfft_ram #(
    .Width(2 * SW),
    .Depth(rcfft_pkg::Points)
  ) u_bins (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(ram_raddr_a),
    .rdata_a_o(ram_rdata_a),
    .raddr_b_i(ram_raddr_b),
    .rdata_b_o(ram_rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcfft_pkg::ST_IDLE;
      dir_cfg_q   <= 1'b0;
      dir_q       <= 1'b0;
      done_q      <= 1'b0;
      load_cnt_q  <= '0;
      stage_q     <= '0;
      bfly_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) dir_cfg_q <= cfg_direction_i;
      if (is_load) begin
        done_q     <= 1'b0;
        load_cnt_q <= load_cnt_q + LogN'(1);
        if (last_load) begin
          dir_q   <= dir_cfg_q;
          stage_q <= '0;
          bfly_q  <= '0;
        end
      end
      if (state_q == rcfft_pkg::ST_BF_WB) begin
        bfly_q <= bfly_q + rcfft_pkg::BflyW'(1);
        if (bfly_q == {rcfft_pkg::BflyW{1'b1}}) stage_q <= stage_q + rcfft_pkg::StageW'(1);
        if (last_bfly) done_q <= 1'b1;
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if ((is_read && !done_q) || state_q == rcfft_pkg::ST_RDBIN) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_read && !done_q) begin
      bin_re_q    <= '0;
      bin_im_q    <= '0;
      valid_res_q <= 1'b0;
    end else if (state_q == rcfft_pkg::ST_RDBIN) begin
      bin_re_q    <= sat_out(ra_re);
      bin_im_q    <= sat_out(ra_im);
      valid_res_q <= 1'b1;
    end
    if (state_q == rcfft_pkg::ST_BF_RD) begin
      wr_q <= rcfft_pkg::TwCos[tw_idx];
      wi_q <= dir_q ? -rcfft_pkg::TwSin[tw_idx] : rcfft_pkg::TwSin[tw_idx];
    end
    if (state_q == rcfft_pkg::ST_BF_MUL) begin
      a_re_q <= ra_re;
      a_im_q <= ra_im;
      prr_q  <= wr_q * b_re;
      pii_q  <= wi_q * b_im;
      pri_q  <= wr_q * b_im;
      pir_q  <= wi_q * b_re;
    end
    if (state_q == rcfft_pkg::ST_BF_SUM) begin
      t_re_q <= sum_re[SuW-1:rcfft_pkg::FracBits];
      t_im_q <= sum_im[SuW-1:rcfft_pkg::FracBits];
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_re_o    = bin_re_q;
  assign bin_im_o    = bin_im_q;
  assign valid_res_o = valid_res_q;

  `RCF_ASSERT_NOW(a_accept_idle, in_acc, state_q == rcfft_pkg::ST_IDLE,
                  "item accepted while the sequencer is busy")
  `RCF_ASSERT_NEXT(a_bfly_order, state_q == rcfft_pkg::ST_BF_RD,
                   state_q == rcfft_pkg::ST_BF_MUL, "butterfly read not followed by multiply")
  `RCF_ASSERT_NOW(a_valid_res_done, out_valid_q && valid_res_q, done_q,
                  "valid bin presented without a finished transform")
  `RCF_ASSERT_NEXT(a_finish_done, state_q == rcfft_pkg::ST_BF_WB && last_bfly,
                   done_q && state_q == rcfft_pkg::ST_IDLE, "last butterfly did not finish")

endmodule

`default_nettype wire
